// ===== sv/spimfb_pkg.sv =====
// Shared types and constants for the byte-wide SPI master.
// Depends on nothing; all files but spimfb_fifo refer to it by scoped names.
package spimfb_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TICK     = 2'd1,
      OP_SELECT   = 2'd2,
      OP_DESELECT = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_SPI_MODE    = 2'd0;
   localparam logic [1:0] CSR_LSB_FIRST   = 2'd1;
   localparam logic [1:0] CSR_FILLER_BYTE = 2'd2;
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd3;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [2:0]  LAST_BIT        = 3'd7;
   localparam logic [7:0]  FILLER_RESET    = 8'hFF;
   localparam logic [15:0] HALF_RESET      = 16'd1;

   typedef struct packed {
      op_type     operation;
      logic [7:0] tx_byte;
      logic       use_filler;
      logic       miso_level;
   } req_type;

   typedef struct packed {
      logic       sclk_level;
      logic       mosi_level;
      logic       select_n;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   // Classified request handed from the front end to the shift engine
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       miso_level;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  spi_mode;
      logic        lsb_first;
      logic [7:0]  filler_byte;
      logic [15:0] half_period_ticks;
   } cfg_type;

endpackage

// ===== sv/spi_master_four_mode_byte.sv =====
// A request is registered in the command queue, then in the result queue, which drives rsp_data.
// Throughput: one request per cycle if the result queue has room; one engine state update each.
// Two-entry queues sit before and after the engine, so each side stalls on its own.
// Reset (synchronous, active high) empties both queues, idles the engine with
// select deasserted, and loads the registers with mode 0, MSB first, filler 0xFF, half period 1.
module spi_master_four_mode_byte (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   input  spimfb_pkg::req_type                      req_data,
   output logic                                     req_full,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output spimfb_pkg::rsp_type                      rsp_data,
   input  logic                                     csr_write_en,
   input  logic [spimfb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [spimfb_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned CmdWidth = $bits(spimfb_pkg::cmd_type);
   localparam int unsigned RspWidth = $bits(spimfb_pkg::rsp_type);

   spimfb_pkg::cfg_type cfg_ff;
   spimfb_pkg::cfg_type cfg_in;
   spimfb_pkg::cmd_type front_cmd;
   spimfb_pkg::cmd_type head_cmd;
   spimfb_pkg::rsp_type engine_rsp;
   logic                cmd_push;
   logic                cmd_full;
   logic                cmd_empty;
   logic                rsp_full;
   logic                cmd_take;
   logic [CmdWidth-1:0] head_cmd_bits;
   logic [RspWidth-1:0] rsp_bits;

   // Register file: a write lands at the next edge; write only while no request is in flight
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            spimfb_pkg::CSR_SPI_MODE:    cfg_in.spi_mode          = csr_wdata[1:0];
            spimfb_pkg::CSR_LSB_FIRST:   cfg_in.lsb_first         = csr_wdata[0];
            spimfb_pkg::CSR_FILLER_BYTE: cfg_in.filler_byte       = csr_wdata[7:0];
            spimfb_pkg::CSR_HALF_PERIOD: cfg_in.half_period_ticks = csr_wdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spi_mode          <= 2'd0;
         cfg_ff.lsb_first         <= 1'b0;
         cfg_ff.filler_byte       <= spimfb_pkg::FILLER_RESET;
         cfg_ff.half_period_ticks <= spimfb_pkg::HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify the request and resolve the dummy byte
   spimfb_front u_front (
      .req_push    (req_push),
      .req_data    (req_data),
      .queue_full  (cmd_full),
      .filler_byte (cfg_ff.filler_byte),
      .cmd_push    (cmd_push),
      .cmd_data    (front_cmd)
   );

   assign req_full = cmd_full;

   // Command queue between front end and engine
   spimfb_fifo #(
      .DATA_WIDTH (CmdWidth)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_take),
      .pop_data  (head_cmd_bits),
      .empty     (cmd_empty)
   );

   assign head_cmd = spimfb_pkg::cmd_type'(head_cmd_bits);

   // Advance the engine only when the result has somewhere to go
   assign cmd_take = ~cmd_empty & ~rsp_full;

   spimfb_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd_take (cmd_take),
      .cmd_data (head_cmd),
      .cfg      (cfg_ff),
      .rsp_data (engine_rsp)
   );

   // Result queue: hold finished requests until the consumer pops them
   spimfb_fifo #(
      .DATA_WIDTH (RspWidth)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_take),
      .push_data (engine_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = spimfb_pkg::rsp_type'(rsp_bits);

   // A completed byte always ends the transfer
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.rx_valid) |-> !rsp_data.busy_res)
      else $error("completed byte reported while still busy");

   // A rejected load leaves the running transfer untouched
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.rejected) |-> (rsp_data.busy_res && !rsp_data.rx_valid))
      else $error("rejected load without a transfer in progress");

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // The engine never drops a result into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_full |-> !cmd_take)
      else $error("engine advanced with the result queue full");

endmodule

// ===== sv/spimfb_fifo.sv =====
// Two-entry queue used between the front end, the shift engine and the result port.
// Depends on nothing; payload is a flat vector of DATA_WIDTH bits.
module spimfb_fifo #(
   parameter int unsigned DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [DATA_WIDTH-1:0] mem_ff [2];
   logic                  wr_ptr_ff;
   logic                  wr_ptr_in;
   logic                  rd_ptr_ff;
   logic                  rd_ptr_in;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/spimfb_front.sv =====
// Front end: classifies an incoming request and resolves the transmit byte.
// Depends on spimfb_pkg.
module spimfb_front (
   input  logic                 req_push,
   input  spimfb_pkg::req_type  req_data,
   input  logic                 queue_full,
   input  logic [7:0]           filler_byte,
   output logic                 cmd_push,
   output spimfb_pkg::cmd_type  cmd_data
);

   assign cmd_push = req_push & ~queue_full;

   always_comb begin
      cmd_data.op         = req_data.operation;
      cmd_data.miso_level = req_data.miso_level;
      cmd_data.tx_byte    = req_data.tx_byte;
      // substitute the dummy byte on loads without transmit data
      if (req_data.operation == spimfb_pkg::OP_LOAD && req_data.use_filler) begin
         cmd_data.tx_byte = filler_byte;
      end
   end

endmodule

// ===== sv/spimfb_engine.sv =====
// Back end: bit timing, shift registers, pin state; one request per cycle on cmd_take.
// Depends on spimfb_pkg.
module spimfb_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_take,
   input  spimfb_pkg::cmd_type  cmd_data,
   input  spimfb_pkg::cfg_type  cfg,
   output spimfb_pkg::rsp_type  rsp_data
);

   logic [7:0]  tx_shift_ff,   tx_shift_in;
   logic [7:0]  rx_accum_ff,   rx_accum_in;
   logic [2:0]  bits_done_ff,  bits_done_in;
   logic        half_phase_ff, half_phase_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        active_ff,     active_in;
   logic        clock_pin_ff,  clock_pin_in;
   logic        data_pin_ff,   data_pin_in;
   logic        select_pin_ff, select_pin_in;

   logic        cpol;
   logic        cpha;
   logic        lead_level;
   logic [15:0] limit;
   logic [16:0] count_next;
   logic [2:0]  next_bits;
   logic [7:0]  accum_next;
   logic [7:0]  rx_out;
   logic        rx_valid;
   logic        rejected;

   // MSB first walks the index down from seven
   function automatic logic [2:0] bit_index(input logic [2:0] bits, input logic lsb);
      bit_index = bits ^ {3{~lsb}};
   endfunction

   assign cpol       = cfg.spi_mode[1];
   assign cpha       = cfg.spi_mode[0];
   assign lead_level = cpha ? ~cpol : cpol;
   assign limit      = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
   assign count_next = {1'b0, tick_count_ff} + 17'd1;
   assign next_bits  = bits_done_ff + 3'd1;
   assign accum_next = rx_accum_ff |
                       ({7'd0, cmd_data.miso_level} << bit_index(bits_done_ff, cfg.lsb_first));

   always_comb begin
      tx_shift_in   = tx_shift_ff;
      rx_accum_in   = rx_accum_ff;
      bits_done_in  = bits_done_ff;
      half_phase_in = half_phase_ff;
      tick_count_in = tick_count_ff;
      active_in     = active_ff;
      clock_pin_in  = clock_pin_ff;
      data_pin_in   = data_pin_ff;
      select_pin_in = select_pin_ff;
      rx_out        = 8'd0;
      rx_valid      = 1'b0;
      rejected      = 1'b0;
      if (cmd_take) begin
         case (cmd_data.op)
            spimfb_pkg::OP_LOAD: begin
               if (active_ff) begin
                  rejected = 1'b1;
               end else begin
                  tx_shift_in   = cmd_data.tx_byte;
                  rx_accum_in   = 8'd0;
                  bits_done_in  = 3'd0;
                  half_phase_in = 1'b0;
                  tick_count_in = 16'd0;
                  active_in     = 1'b1;
                  data_pin_in   = cmd_data.tx_byte[bit_index(3'd0, cfg.lsb_first)];
                  clock_pin_in  = lead_level;
               end
            end
            spimfb_pkg::OP_TICK: begin
               if (active_ff) begin
                  if (count_next >= {1'b0, limit}) begin
                     tick_count_in = 16'd0;
                     if (!half_phase_ff) begin
                        clock_pin_in  = cpha ? cpol : ~cpol;
                        half_phase_in = 1'b1;
                     end else begin
                        half_phase_in = 1'b0;
                        rx_accum_in   = accum_next;
                        clock_pin_in  = cpol;
                        if (bits_done_ff == spimfb_pkg::LAST_BIT) begin
                           active_in = 1'b0;
                           rx_valid  = 1'b1;
                           rx_out    = accum_next;
                        end else begin
                           bits_done_in = next_bits;
                           data_pin_in  = tx_shift_ff[bit_index(next_bits, cfg.lsb_first)];
                           clock_pin_in = lead_level;
                        end
                     end
                  end else begin
                     tick_count_in = count_next[15:0];
                  end
               end
            end
            spimfb_pkg::OP_SELECT: begin
               select_pin_in = 1'b0;
            end
            spimfb_pkg::OP_DESELECT: begin
               select_pin_in = 1'b1;
            end
            default: begin
               select_pin_in = select_pin_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data.sclk_level = active_in ? clock_pin_in : cpol;
      rsp_data.mosi_level = data_pin_in;
      rsp_data.select_n   = select_pin_in;
      rsp_data.rx_byte    = rx_out;
      rsp_data.rx_valid   = rx_valid;
      rsp_data.busy_res   = active_in;
      rsp_data.rejected   = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff   <= 8'd0;
         rx_accum_ff   <= 8'd0;
         bits_done_ff  <= 3'd0;
         half_phase_ff <= 1'b0;
         tick_count_ff <= 16'd0;
         active_ff     <= 1'b0;
         clock_pin_ff  <= 1'b0;
         data_pin_ff   <= 1'b0;
         select_pin_ff <= 1'b1;
      end else begin
         tx_shift_ff   <= tx_shift_in;
         rx_accum_ff   <= rx_accum_in;
         bits_done_ff  <= bits_done_in;
         half_phase_ff <= half_phase_in;
         tick_count_ff <= tick_count_in;
         active_ff     <= active_in;
         clock_pin_ff  <= clock_pin_in;
         data_pin_ff   <= data_pin_in;
         select_pin_ff <= select_pin_in;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the byte-wide four-mode SPI master (spi_master_four_mode_byte).
// Depends on spimfb_pkg for the request, response and register types and on the RTL alone.
module tb_top;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned BUSY_TARGET  = 550;

   // Responses that can be read straight off the spec
   localparam spimfb_pkg::rsp_type RSP_IDLE_OFF = '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam spimfb_pkg::rsp_type RSP_IDLE_ON  = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam spimfb_pkg::rsp_type RSP_REJECT   = '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1};

   typedef struct {
      spimfb_pkg::req_type req;
      bit                  typed;
      spimfb_pkg::rsp_type want;
   } script_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_push = 1'b0;
   spimfb_pkg::req_type                    req_data = '0;
   logic                                   req_full;
   logic                                   rsp_empty;
   logic                                   rsp_pop = 1'b0;
   spimfb_pkg::rsp_type                    rsp_data;
   logic                                   csr_write_en = 1'b0;
   logic [spimfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [spimfb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Typed expectation travelling alongside the request on the bus
   bit                  row_typed = 1'b0;
   spimfb_pkg::rsp_type row_want = '0;

   script_row_type      script[$];
   spimfb_pkg::rsp_type pending_pins[$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned pop_style = 0;
   int unsigned pop_age = 0;

   // Shadow copy of the SPI engine: registers, shifter and pin levels
   spimfb_pkg::cfg_type cfg;
   logic [7:0]  tx_sh;
   logic [7:0]  rx_sh;
   logic [2:0]  bit_pos;
   logic        second_half;
   logic [15:0] tick_cnt;
   logic        shifting;
   logic        sclk_q;
   logic        mosi_q;
   logic        ss_n;

   spi_master_four_mode_byte dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [2:0] bit_slot();
      return cfg.lsb_first ? bit_pos : spimfb_pkg::LAST_BIT - bit_pos;
   endfunction

   // Put the next data bit on MOSI and park the clock at its leading level
   function automatic void start_bit();
      mosi_q = tx_sh[bit_slot()];
      sclk_q = cfg.spi_mode[0] ? ~cfg.spi_mode[1] : cfg.spi_mode[1];
   endfunction

   function automatic spimfb_pkg::rsp_type next_pin_state(input spimfb_pkg::req_type r);
      spimfb_pkg::rsp_type o;
      logic        cpol;
      logic        cpha;
      logic [16:0] span;
      logic [16:0] next_cnt;
      o = '0;
      cpol = cfg.spi_mode[1];
      cpha = cfg.spi_mode[0];
      case (r.operation)
         spimfb_pkg::OP_LOAD: begin
            if (shifting) begin
               o.rejected = 1'b1;
            end else begin
               tx_sh       = r.use_filler ? cfg.filler_byte : r.tx_byte;
               rx_sh       = '0;
               bit_pos     = '0;
               second_half = 1'b0;
               tick_cnt    = '0;
               shifting    = 1'b1;
               start_bit();
            end
         end
         spimfb_pkg::OP_TICK: begin
            // ticks while idle fall through untouched, MISO ignored
            if (shifting) begin
               span     = (cfg.half_period_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.half_period_ticks};
               next_cnt = {1'b0, tick_cnt} + 17'd1;
               if (next_cnt >= span) begin
                  tick_cnt = '0;
                  if (!second_half) begin
                     sclk_q      = cpha ? cpol : ~cpol;
                     second_half = 1'b1;
                  end else begin
                     // end of the second delay: sample MISO, return clock to idle level
                     second_half = 1'b0;
                     if (r.miso_level) rx_sh[bit_slot()] = 1'b1;
                     sclk_q = cpol;
                     if (bit_pos == spimfb_pkg::LAST_BIT) begin
                        shifting   = 1'b0;
                        o.rx_valid = 1'b1;
                        o.rx_byte  = rx_sh;
                     end else begin
                        bit_pos = bit_pos + 3'd1;
                        start_bit();
                     end
                  end
               end else begin
                  tick_cnt = next_cnt[15:0];
               end
            end
         end
         spimfb_pkg::OP_SELECT: ss_n = 1'b0;
         default:               ss_n = 1'b1;
      endcase
      o.sclk_level = shifting ? sclk_q : cfg.spi_mode[1];
      o.mosi_level = mosi_q;
      o.select_n   = ss_n;
      o.busy_res   = shifting;
      return o;
   endfunction

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Track register writes and accepted requests in bus order, then score each popped result
   always @(posedge clock) begin
      spimfb_pkg::rsp_type want;
      if (reset) begin
         cfg         = '{2'd0, 1'b0, spimfb_pkg::FILLER_RESET, spimfb_pkg::HALF_RESET};
         tx_sh       = '0;
         rx_sh       = '0;
         bit_pos     = '0;
         second_half = 1'b0;
         tick_cnt    = '0;
         shifting    = 1'b0;
         sclk_q      = 1'b0;
         mosi_q      = 1'b0;
         ss_n        = 1'b1;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               spimfb_pkg::CSR_SPI_MODE:    cfg.spi_mode          = csr_wdata[1:0];
               spimfb_pkg::CSR_LSB_FIRST:   cfg.lsb_first         = csr_wdata[0];
               spimfb_pkg::CSR_FILLER_BYTE: cfg.filler_byte       = csr_wdata[7:0];
               spimfb_pkg::CSR_HALF_PERIOD: cfg.half_period_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            want = next_pin_state(req_data);
            pending_pins.push_back(row_typed ? row_want : want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_pins.size() == 0) begin
               errors++;
               $display("%0t: response with no request outstanding, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = pending_pins.pop_front();
               check_field("sclk_level", 8'(want.sclk_level), 8'(rsp_data.sclk_level));
               check_field("mosi_level", 8'(want.mosi_level), 8'(rsp_data.mosi_level));
               check_field("select_n",   8'(want.select_n),   8'(rsp_data.select_n));
               check_field("rx_byte",    want.rx_byte,        rsp_data.rx_byte);
               check_field("rx_valid",   8'(want.rx_valid),   8'(rsp_data.rx_valid));
               check_field("busy_res",   8'(want.busy_res),   8'(rsp_data.busy_res));
               check_field("rejected",   8'(want.rejected),   8'(rsp_data.rejected));
            end
         end
      end
   end

   // Receiver: pick a pop style for a random stretch, from free-running to heavy stalls
   always @(negedge clock) begin
      if (pop_age == 0) begin
         pop_style <= $urandom_range(0, 3);
         pop_age   <= $urandom_range(20, 80);
      end else begin
         pop_age <= pop_age - 1;
      end
      case (pop_style)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= 1'($urandom_range(0, 1));
         2:       rsp_pop <= ($urandom_range(0, 7) == 0);
         default: rsp_pop <= (pop_age[2:0] != 3'd0);
      endcase
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driver

   function automatic void add_row(input spimfb_pkg::op_type op, input logic [7:0] tx,
                                   input logic fill, input logic miso, input bit typed,
                                   input spimfb_pkg::rsp_type want);
      script_row_type row;
      row.req.operation  = op;
      row.req.tx_byte    = tx;
      row.req.use_filler = fill;
      row.req.miso_level = miso;
      row.typed          = typed;
      row.want           = want;
      script.push_back(row);
   endfunction

   // Call at a falling edge; hold the request until the block takes it
   task automatic send_request(input spimfb_pkg::req_type r, input bit typed,
                               input spimfb_pkg::rsp_type want);
      req_data  <= r;
      req_push  <= 1'b1;
      row_typed <= typed;
      row_want  <= want;
      do @(posedge clock); while (req_full);
   endtask

   task automatic hold_off(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
   endtask

   // Drop push and wait for every outstanding response, plus the pipeline latency
   task automatic drain();
      hold_off(1);
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [15:0] d);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= d;
      @(posedge clock);
   endtask

   // Upper bits of narrow registers carry junk; the block must mask them off
   task automatic write_regs(input logic [3:0] pick, input spimfb_pkg::cfg_type v);
      logic [15:0] junk;
      junk = 16'($urandom);
      if (pick[spimfb_pkg::CSR_SPI_MODE])
         put_reg(spimfb_pkg::CSR_SPI_MODE, {junk[15:2], v.spi_mode});
      if (pick[spimfb_pkg::CSR_LSB_FIRST])
         put_reg(spimfb_pkg::CSR_LSB_FIRST, {junk[15:1], v.lsb_first});
      if (pick[spimfb_pkg::CSR_FILLER_BYTE])
         put_reg(spimfb_pkg::CSR_FILLER_BYTE, {junk[15:8], v.filler_byte});
      if (pick[spimfb_pkg::CSR_HALF_PERIOD])
         put_reg(spimfb_pkg::CSR_HALF_PERIOD, v.half_period_ticks);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly well-formed traffic: load when idle, clock the byte out when busy
   function automatic spimfb_pkg::req_type random_request();
      spimfb_pkg::req_type r;
      int unsigned         roll;
      r.tx_byte    = 8'($urandom);
      r.use_filler = ($urandom_range(0, 3) == 0);
      r.miso_level = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (shifting)
         r.operation = (roll < 88) ? spimfb_pkg::OP_TICK :
                       (roll < 92) ? spimfb_pkg::OP_LOAD :
                       (roll < 96) ? spimfb_pkg::OP_SELECT : spimfb_pkg::OP_DESELECT;
      else
         r.operation = (roll < 55) ? spimfb_pkg::OP_LOAD :
                       (roll < 75) ? spimfb_pkg::OP_TICK :
                       (roll < 88) ? spimfb_pkg::OP_SELECT : spimfb_pkg::OP_DESELECT;
      return r;
   endfunction

   initial begin
      spimfb_pkg::cfg_type v;
      spimfb_pkg::req_type r;
      logic [3:0]  pick;
      int unsigned busy_items;
      int unsigned phase_no;
      int unsigned len;
      int unsigned burst_left;
      int unsigned roll;

      // Directed script at reset settings: mode 0, MSB first, filler 0xFF, half period 1.
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b1, RSP_IDLE_OFF); // idle tick ignored
      add_row(spimfb_pkg::OP_DESELECT, 8'h00, 1'b0, 1'b0, 1'b1, RSP_IDLE_OFF);
      add_row(spimfb_pkg::OP_SELECT,   8'h00, 1'b0, 1'b0, 1'b1, RSP_IDLE_ON);
      add_row(spimfb_pkg::OP_LOAD,     8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_LOAD,     8'h00, 1'b1, 1'b1, 1'b1, RSP_REJECT);   // load while busy
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_DESELECT, 8'hFF, 1'b1, 1'b1, 1'b0, '0);   // select change mid-byte
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_SELECT,   8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);   // last bit, first half of its clock
      add_row(spimfb_pkg::OP_LOAD,     8'h00, 1'b1, 1'b0, 1'b0, '0);   // filler load while busy, rejected
      add_row(spimfb_pkg::OP_TICK,     8'h00, 1'b0, 1'b1, 1'b0, '0);
      add_row(spimfb_pkg::OP_DESELECT, 8'h00, 1'b0, 1'b0, 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         @(negedge clock);
         send_request(script[i].req, script[i].typed, script[i].want);
      end
      drain();

      // Extremes: mode 3, LSB first, filler 0x00, half period 0 (acts as one)
      write_regs(4'hF, '{2'd3, 1'b1, 8'h00, 16'd0});

      busy_items = 0;
      phase_no   = 0;
      while (busy_items < BUSY_TARGET) begin
         v.spi_mode  = 2'($urandom_range(0, 3));
         v.lsb_first = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0:       v.filler_byte = 8'h00;
            1:       v.filler_byte = 8'hFF;
            default: v.filler_byte = 8'($urandom);
         endcase
         roll = $urandom_range(0, 9);
         v.half_period_ticks = (roll < 6) ? 16'($urandom_range(0, 3)) :
                               (roll < 9) ? 16'($urandom_range(4, 12)) : 16'($urandom);
         pick = 4'($urandom_range(1, 15));
         len  = $urandom_range(20, 60);
         // Slowest half period first, then drop it mid-delay so the delay ends next tick
         if (phase_no == 0) begin
            pick = 4'b0;
            pick[spimfb_pkg::CSR_HALF_PERIOD] = 1'b1;
            v.half_period_ticks = 16'hFFFF;
         end
         if (phase_no == 1) begin
            pick[spimfb_pkg::CSR_HALF_PERIOD] = 1'b1;
            v.half_period_ticks = 16'd2;
         end
         if (cfg.half_period_ticks > 16'd12) pick[spimfb_pkg::CSR_HALF_PERIOD] = 1'b1;
         if (v.half_period_ticks > 16'd12 && pick[spimfb_pkg::CSR_HALF_PERIOD]) len = 15;
         write_regs(pick, v);

         burst_left = 0;
         repeat (len) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
            end
            burst_left--;
            @(negedge clock);
            r = random_request();
            if (r.operation != spimfb_pkg::OP_TICK || shifting) busy_items++;
            send_request(r, 1'b0, '0);
         end
         // Pause until every response is back before touching the registers
         drain();
         phase_no++;
      end

      repeat (8) @(posedge clock);
      if (errors == 0 && pending_pins.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
